// File: rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is asserted.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) else $error("assertion failed");

`endif

// File: rtl/pcc_pkg.sv
// Types and constants for the polygon convexity check.
package pcc_pkg;

  typedef enum logic [2:0] {
    SEEN_NONE = 3'b001,
    SEEN_ONE  = 3'b010,
    SEEN_MANY = 3'b100
  } seen_e;

  typedef struct packed {
    logic cw;
    logic x_flip;
    logic y_flip;
  } turn_t;

  localparam logic [1:0] FLIP_MAX   = 2'd3;
  localparam logic [2:0] FLIP_LIMIT = 3'd2;

endpackage

// File: rtl/pcc_turn.sv
// One turn test between two consecutive edges: clockwise flag and sign flips.
module pcc_turn
  import pcc_pkg::*;
#(
  parameter int EDGE_BITS = 17
) (
  input  logic signed [EDGE_BITS-1:0] ax_i,
  input  logic signed [EDGE_BITS-1:0] ay_i,
  input  logic signed [EDGE_BITS-1:0] bx_i,
  input  logic signed [EDGE_BITS-1:0] by_i,
  output turn_t                       turn_o
);

  logic signed [2*EDGE_BITS-1:0] prod_ab;
  logic signed [2*EDGE_BITS-1:0] prod_ba;

  assign prod_ab = ax_i * by_i;
  assign prod_ba = ay_i * bx_i;

  assign turn_o.cw     = prod_ab < prod_ba;
  assign turn_o.x_flip = ax_i[EDGE_BITS-1] ^ bx_i[EDGE_BITS-1];
  assign turn_o.y_flip = ay_i[EDGE_BITS-1] ^ by_i[EDGE_BITS-1];

endmodule

// File: rtl/polygon_convexity_check.sv
// Polygon convexity check: streams vertices, reports convexity on the last vertex.
// Path: a final vertex passes the input register, then the output register.
// Throughput: one vertex per cycle while no final vertex waits behind an
// unaccepted result; edge and three cross products use the input register.
// Reset: asynchronous, active low; clears both stages and starts a new polygon.
module polygon_convexity_check
  import pcc_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // vx, vy, zero pad
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata_i,
  // final_vertex
  input  logic                                  s_axis_tlast_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // convex, too_short, zero pad
  output logic [7:0]                            m_axis_tdata_o
);

  localparam int EdgeW = COORD_BITS + 1;

  // input register
  logic                         in_valid_q, in_valid_d;
  logic signed [COORD_BITS-1:0] vx_q, vy_q;
  logic                         in_last_q;

  // polygon state
  seen_e                        seen_q, seen_d;
  logic [1:0]                   x_flips_q, x_flips_d, y_flips_q, y_flips_d;
  logic                         failed_q, failed_d;
  logic signed [COORD_BITS-1:0] start_x_q, start_y_q, last_x_q, last_y_q;
  logic signed [EdgeW-1:0]      start_ex_q, start_ey_q, last_ex_q, last_ey_q;

  // output register
  logic                         out_valid_q, out_valid_d;
  logic                         convex_q, too_short_q;

  logic                         s_fire, out_free, advance;
  logic signed [EdgeW-1:0]      edge_x, edge_y, close_x, close_y;
  turn_t                        turn_new, turn_close, turn_wrap;
  logic [2:0]                   x_step, y_step, x_all, y_all;
  logic                         enough, convex_d;

  assign s_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign advance  = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready_o = !in_valid_q || advance;

  assign edge_x  = EdgeW'(vx_q) - EdgeW'(last_x_q);
  assign edge_y  = EdgeW'(vy_q) - EdgeW'(last_y_q);
  assign close_x = EdgeW'(start_x_q) - EdgeW'(vx_q);
  assign close_y = EdgeW'(start_y_q) - EdgeW'(vy_q);

  pcc_turn #(.EDGE_BITS(EdgeW)) u_turn_new (
    .ax_i(last_ex_q), .ay_i(last_ey_q), .bx_i(edge_x), .by_i(edge_y), .turn_o(turn_new)
  );

  pcc_turn #(.EDGE_BITS(EdgeW)) u_turn_close (
    .ax_i(edge_x), .ay_i(edge_y), .bx_i(close_x), .by_i(close_y), .turn_o(turn_close)
  );

  pcc_turn #(.EDGE_BITS(EdgeW)) u_turn_wrap (
    .ax_i(close_x), .ay_i(close_y), .bx_i(start_ex_q), .by_i(start_ey_q),
    .turn_o(turn_wrap)
  );

  assign enough = (seen_q == SEEN_MANY);
  assign x_step = {1'b0, x_flips_q} + {2'b00, turn_new.x_flip};
  assign y_step = {1'b0, y_flips_q} + {2'b00, turn_new.y_flip};
  assign x_all  = x_step + {2'b00, turn_close.x_flip} + {2'b00, turn_wrap.x_flip};
  assign y_all  = y_step + {2'b00, turn_close.y_flip} + {2'b00, turn_wrap.y_flip};
  assign convex_d = enough && !(failed_q || turn_new.cw || turn_close.cw || turn_wrap.cw)
                    && (x_all <= FLIP_LIMIT) && (y_all <= FLIP_LIMIT);

  always_comb begin
    seen_d    = seen_q;
    x_flips_d = x_flips_q;
    y_flips_d = y_flips_q;
    failed_d  = failed_q;
    if (advance) begin
      unique case (seen_q)
        SEEN_NONE: seen_d = SEEN_ONE;
        SEEN_ONE:  seen_d = SEEN_MANY;
        SEEN_MANY: begin
          x_flips_d = (x_step > {1'b0, FLIP_MAX}) ? FLIP_MAX : x_step[1:0];
          y_flips_d = (y_step > {1'b0, FLIP_MAX}) ? FLIP_MAX : y_step[1:0];
          failed_d  = failed_q || turn_new.cw;
        end
        default: seen_d = SEEN_NONE;
      endcase
      if (in_last_q) begin
        seen_d    = SEEN_NONE;
        x_flips_d = '0;
        y_flips_d = '0;
        failed_d  = 1'b0;
      end
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_fire) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance && in_last_q) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      seen_q      <= SEEN_NONE;
      x_flips_q   <= '0;
      y_flips_q   <= '0;
      failed_q    <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      seen_q      <= seen_d;
      x_flips_q   <= x_flips_d;
      y_flips_q   <= y_flips_d;
      failed_q    <= failed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      vx_q      <= s_axis_tdata_i[COORD_BITS-1:0];
      vy_q      <= s_axis_tdata_i[2*COORD_BITS-1:COORD_BITS];
      in_last_q <= s_axis_tlast_i;
    end
    if (advance) begin
      last_x_q <= vx_q;
      last_y_q <= vy_q;
      if (seen_q == SEEN_NONE) begin
        start_x_q <= vx_q;
        start_y_q <= vy_q;
      end
      if (seen_q == SEEN_ONE) begin
        start_ex_q <= edge_x;
        start_ey_q <= edge_y;
      end
      if (seen_q != SEEN_NONE) begin
        last_ex_q <= edge_x;
        last_ey_q <= edge_y;
      end
      if (in_last_q) begin
        convex_q    <= convex_d;
        too_short_q <= !enough;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, too_short_q, convex_q};

endmodule

// File: rtl/pcc_checker.sv
// Port-level checks for the polygon convexity check, bound to the top level.
`include "assert_macros.svh"

module pcc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic       s_axis_tlast_i,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o
);

  logic s_fire_last, out_stall;
  assign s_fire_last = s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i;
  assign out_stall   = m_axis_tvalid_o && !m_axis_tready_i;

  // stalled result holds
  `ASSERT_CLK(a_out_hold, out_stall |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
  // a result is never both convex and too short
  `ASSERT_CLK(a_out_excl, m_axis_tvalid_o |-> !(m_axis_tdata_o[0] && m_axis_tdata_o[1]))
  // a newly valid result must have an accepted final vertex behind it
  `ASSERT_CLK(a_out_cause, $rose(m_axis_tvalid_o) |-> $past(s_fire_last, 2))
  // input only backs up behind a stalled result
  `ASSERT_CLK(a_in_stall, !s_axis_tready_o |-> out_stall)

endmodule

bind polygon_convexity_check pcc_checker u_pcc_checker (.*);
